@@ rtl/sbd_pkg.sv @@
package sbd_pkg;

    // Lock level of the marker search, as shown on every emitted byte.
    typedef enum logic [1:0] {
        LOCK_NOSYNC  = 2'd0,
        LOCK_SYNCING = 2'd1,
        LOCK_SYNCED  = 2'd2
    } t_lock;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNCING_TOL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNCED_TOL    = 2'd3;

    // Register values after reset.
    localparam logic [15:0] RST_FRAME_BITS  = 16'd4800;
    localparam logic [23:0] RST_MARKER      = 24'hFFFFFF;
    localparam logic [4:0]  RST_SYNCING_TOL = 5'd2;
    localparam logic [4:0]  RST_SYNCED_TOL  = 5'd6;

    // Lock counter thresholds.
    localparam logic [3:0] GOOD_LIMIT = 4'd10;
    localparam logic [1:0] BAD_LIMIT  = 2'd2;

    // Width of the frame bit counter, and the most bytes one request may produce.
    localparam int IDX_W       = 17;
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [15:0] frame_bits;
        logic [23:0] marker;
        logic [4:0]  syncing_tol;
        logic [4:0]  synced_tol;
    } t_cfg;

    // Control part of one queue entry.
    typedef struct packed {
        logic  is_marker;
        logic  eof;
        t_lock lock;
    } t_ctl;

endpackage

@@ rtl/sbd_in_if.sv @@
interface sbd_in_if;
    logic valid;
    logic ready;
    logic bit_in;

    modport source (output valid, output bit_in, input ready);
    modport sink (input valid, input bit_in, output ready);
endinterface

@@ rtl/sbd_out_if.sv @@
interface sbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;
    logic [1:0] lock_state;

    modport source (output valid, output data_byte, output end_of_frame,
                    output lock_state, input ready);
    modport sink (input valid, input data_byte, input end_of_frame,
                  input lock_state, output ready);
endinterface

@@ rtl/sbd_queue.sv @@
module sbd_queue #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

@@ rtl/sbd_front.sv @@
module sbd_front
    import sbd_pkg::*;
#(
    parameter int MARKER_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    sbd_in_if.sink                 i_bits,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [MARKER_BITS-1:0] o_word,
    output t_ctl                   o_ctl
);
    localparam int DW    = $clog2(MARKER_BITS + 1);
    localparam int CW    = (DW > 5) ? DW : 5;
    localparam int LEAST = ((MARKER_BITS + 7) / 8) * 8 + 8;

    logic [MARKER_BITS-1:0] r_window;
    logic                   r_framing;
    logic                   r_pol;
    t_lock                  r_lock;
    logic [3:0]             r_good;
    logic [1:0]             r_bad;
    logic [IDX_W-1:0]       r_idx;
    logic [7:0]             r_byte;

    t_lock                  n_lock;
    logic [3:0]             n_good;
    logic [1:0]             n_bad;
    logic                   n_pol;

    logic                   w_take;
    logic                   w_start;
    logic [15:0]            w_len_raw;
    logic [15:0]            w_len;
    logic [MARKER_BITS-1:0] w_win;
    logic [MARKER_BITS-1:0] w_marker;
    logic [MARKER_BITS-1:0] w_inverse;
    logic [MARKER_BITS-1:0] w_diff;
    logic [DW-1:0]          w_dist;
    logic                   w_hit_syncing;
    logic                   w_hit_synced;
    logic                   w_exact_true;
    logic                   w_exact_inv;
    logic [3:0]             w_good_inc;
    logic [1:0]             w_bad_inc;
    logic [IDX_W-1:0]       w_idx_next;
    logic [7:0]             w_byte_next;
    logic                   w_emit;
    logic                   w_eof;
    logic                   w_done;

    assign i_bits.ready = !i_full;
    assign w_take       = i_bits.valid && i_bits.ready;

    // Effective frame length: whole bytes, never shorter than marker plus one byte.
    assign w_len_raw = {i_cfg.frame_bits[15:3], 3'b000};
    assign w_len     = (w_len_raw < 16'(LEAST)) ? 16'(LEAST) : w_len_raw;

    // Window after this bit, and its distance from the expected marker.
    assign w_win     = {r_window[MARKER_BITS-2:0], i_bits.bit_in};
    assign w_marker  = MARKER_BITS'(i_cfg.marker);
    assign w_inverse = ~w_marker;
    assign w_diff    = w_win ^ (r_pol ? w_inverse : w_marker);

    always_comb begin
        w_dist = '0;
        for (int i = 0; i < MARKER_BITS; i++) begin
            w_dist = w_dist + DW'(w_diff[i]);
        end
    end

    assign w_hit_syncing = CW'(w_dist) < CW'(i_cfg.syncing_tol);
    assign w_hit_synced  = CW'(w_dist) < CW'(i_cfg.synced_tol);
    assign w_exact_true  = (w_win == w_marker);
    assign w_exact_inv   = (w_win == w_inverse);

    // Saturating lock counters.
    assign w_good_inc = (r_good == 4'hF) ? r_good : r_good + 4'd1;
    assign w_bad_inc  = (r_bad == 2'h3) ? r_bad : r_bad + 2'd1;

    // Position within the frame after this bit.
    assign w_idx_next  = r_idx + 1'b1;
    assign w_byte_next = {r_byte[6:0], i_bits.bit_in ^ r_pol};
    assign w_emit      = (w_idx_next[2:0] == 3'd0) && (w_idx_next <= IDX_W'(w_len));
    assign w_eof       = (w_idx_next == IDX_W'(w_len));
    assign w_done      = (w_idx_next == IDX_W'(w_len) + IDX_W'(MARKER_BITS - 1));

    // Next lock level; it only moves at a marker check outside a frame.
    always_comb begin
        n_lock = r_lock;
        if (!r_framing) begin
            case (r_lock)
                LOCK_SYNCING: begin
                    if (w_hit_syncing) begin
                        if (w_good_inc > GOOD_LIMIT) begin
                            n_lock = LOCK_SYNCED;
                        end
                    end else if (w_bad_inc > BAD_LIMIT) begin
                        n_lock = LOCK_NOSYNC;
                    end
                end
                LOCK_SYNCED: begin
                    if (!w_hit_synced) begin
                        n_lock = LOCK_NOSYNC;
                    end
                end
                default: begin
                    if (w_exact_true || w_exact_inv) begin
                        n_lock = LOCK_SYNCING;
                    end
                end
            endcase
        end
    end

    // Counters, polarity and frame start for each lock level.
    always_comb begin
        n_good  = r_good;
        n_bad   = r_bad;
        n_pol   = r_pol;
        w_start = 1'b0;
        if (!r_framing) begin
            case (r_lock)
                LOCK_SYNCING: begin
                    if (w_hit_syncing) begin
                        n_bad   = '0;
                        n_good  = w_good_inc;
                        w_start = 1'b1;
                    end else begin
                        n_good = '0;
                        n_bad  = w_bad_inc;
                    end
                end
                LOCK_SYNCED: begin
                    if (w_hit_synced) begin
                        w_start = 1'b1;
                    end else begin
                        n_good = '0;
                        n_bad  = '0;
                    end
                end
                default: begin
                    if (w_exact_true || w_exact_inv) begin
                        n_pol   = !w_exact_true;
                        n_good  = '0;
                        n_bad   = '0;
                        w_start = 1'b1;
                    end
                end
            endcase
        end
    end

    // Request towards the back end: a completed data byte or a whole marker.
    assign o_push          = w_take && (r_framing ? w_emit : w_start);
    assign o_word          = r_framing ? MARKER_BITS'(w_byte_next) : w_marker;
    assign o_ctl.is_marker = !r_framing;
    assign o_ctl.eof       = r_framing && w_eof;
    assign o_ctl.lock      = n_lock;

    // Search and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_framing <= 1'b0;
            r_pol     <= 1'b0;
            r_lock    <= LOCK_NOSYNC;
            r_good    <= '0;
            r_bad     <= '0;
            r_idx     <= '0;
            r_byte    <= '0;
        end else if (w_take) begin
            r_window <= w_win;
            r_lock   <= n_lock;
            r_good   <= n_good;
            r_bad    <= n_bad;
            r_pol    <= n_pol;
            if (r_framing) begin
                r_byte <= w_byte_next;
                r_idx  <= w_idx_next;
                if (w_done) begin
                    r_framing <= 1'b0;
                end
            end else if (w_start) begin
                r_byte    <= w_marker[7:0];
                r_idx     <= IDX_W'(MARKER_BITS);
                r_framing <= 1'b1;
            end
        end
    end
endmodule

@@ rtl/sbd_back.sv @@
module sbd_back
    import sbd_pkg::*;
#(
    parameter int MARKER_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  logic [MARKER_BITS-1:0] i_word,
    input  t_ctl                   i_ctl,
    output logic                   o_pop,
    sbd_out_if.source              o_bytes
);
    localparam int NB = ((MARKER_BITS / 8) < MAX_RESULTS) ? (MARKER_BITS / 8) : MAX_RESULTS;
    localparam int SW = (NB > 1) ? $clog2(NB) : 1;
    localparam int LN = 1 << SW;

    logic [7:0]    w_lane [LN];
    logic          w_load;
    logic          w_last;
    logic [7:0]    w_sel;

    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_eof;
    t_lock         r_lock;
    logic [SW-1:0] r_sub;

    // Marker bytes, most significant first; lanes past the last byte read zero.
    for (genvar k = 0; k < LN; k++) begin : g_lane
        if (k < NB) begin : g_used
            assign w_lane[k] = i_word[MARKER_BITS-1-8*k -: 8];
        end else begin : g_spare
            assign w_lane[k] = '0;
        end
    end

    assign w_load = !i_empty && (!r_valid || o_bytes.ready);
    assign w_last = !i_ctl.is_marker || (r_sub == SW'(NB - 1));
    assign o_pop  = w_load && w_last;
    assign w_sel  = i_ctl.is_marker ? w_lane[r_sub] : i_word[7:0];

    assign o_bytes.valid        = r_valid;
    assign o_bytes.data_byte    = r_byte;
    assign o_bytes.end_of_frame = r_eof;
    assign o_bytes.lock_state   = r_lock;

    // Output register and marker byte counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_sub   <= w_last ? '0 : r_sub + 1'b1;
        end else if (o_bytes.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_sel;
            r_eof  <= i_ctl.eof;
            r_lock <= i_ctl.lock;
        end
    end
endmodule

@@ rtl/sync_marker_bit_deframer.sv @@
// Frame synchroniser for a serial bit stream. One received bit is taken per
// request, one per clock cycle, with no stall on the input side as long as
// results are taken. Outside a frame the last MARKER_BITS bits are compared with
// the sync marker or its complement; on a hit the marker bytes and then the
// frame bytes are delivered, one byte per output request, the last byte of a
// frame flagged and every byte tagged with the lock level. A marker hit yields
// up to three bytes in one queue entry, held by a four-entry queue while the
// output stage drains one byte per cycle when ready; the following eight bits
// give it time to catch up. Bytes pass the queue, then the output register.
// Configuration is written by the user while the block is idle; not enforced.
module sync_marker_bit_deframer
    import sbd_pkg::*;
#(
    parameter int MARKER_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sbd_in_if.sink                i_bits,
    sbd_out_if.source             o_bytes
);
    localparam int QW = MARKER_BITS + $bits(t_ctl);

    t_cfg                   r_cfg;
    logic                   w_push;
    logic [MARKER_BITS-1:0] w_push_word;
    t_ctl                   w_push_ctl;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_pop;
    logic [QW-1:0]          w_head;
    logic [MARKER_BITS-1:0] w_head_word;
    t_ctl                   w_head_ctl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_bits  <= RST_FRAME_BITS;
            r_cfg.marker      <= RST_MARKER;
            r_cfg.syncing_tol <= RST_SYNCING_TOL;
            r_cfg.synced_tol  <= RST_SYNCED_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_BITS:  r_cfg.frame_bits  <= i_cfg_data[15:0];
                CFG_MARKER:      r_cfg.marker      <= i_cfg_data;
                CFG_SYNCING_TOL: r_cfg.syncing_tol <= i_cfg_data[4:0];
                CFG_SYNCED_TOL:  r_cfg.synced_tol  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Marker search and frame tracking.
    sbd_front #(.MARKER_BITS(MARKER_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_bits  (i_bits),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_word  (w_push_word),
        .o_ctl   (w_push_ctl)
    );

    // Decoupling queue between the two halves.
    sbd_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_word, w_push_ctl}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    assign w_head_word = w_head[QW-1 -: MARKER_BITS];
    assign w_head_ctl  = w_head[$bits(t_ctl)-1:0];

    // Byte delivery.
    sbd_back #(.MARKER_BITS(MARKER_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_word  (w_head_word),
        .i_ctl   (w_head_ctl),
        .o_pop   (w_pop),
        .o_bytes (o_bytes)
    );
endmodule

@@ rtl/sbd_checker.sv @@
module sbd_checker
    import sbd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_eof,
    input logic [1:0] i_out_lock
);
    // A waiting byte stays offered.
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request withdrawn while stalled");

    // A waiting byte keeps its contents.
    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_out_byte, i_out_eof, i_out_lock}))
        else $error("output request changed while stalled");

    // Bytes are only produced once a marker has been found.
    a_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_lock == LOCK_SYNCING || i_out_lock == LOCK_SYNCED))
        else $error("byte delivered without lock");

    // Nothing is offered straight after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output request right after reset");
endmodule

bind sync_marker_bit_deframer sbd_checker u_sbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_bytes.valid),
    .i_out_ready (o_bytes.ready),
    .i_out_byte  (o_bytes.data_byte),
    .i_out_eof   (o_bytes.end_of_frame),
    .i_out_lock  (o_bytes.lock_state)
);
